// File: hdl/usct_pkg.sv
`timescale 1ns / 1ps

package usct_pkg;

  localparam int unsigned MAX_STACKS = 64;
  localparam int unsigned MAX_POINTS = 256;
  localparam int unsigned MIN_STACKS = 2;
  localparam int unsigned MIN_POINTS = 3;

  localparam int unsigned STACK_W = 7;
  localparam int unsigned POINT_W = 9;
  localparam int unsigned RPT_W   = 8;
  localparam int unsigned IDX_W   = 15;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOUR   = 3'd6;

  // Pipelined divider: dividend, divisor, quotient bits per stage
  localparam int unsigned DIV_NW     = 42;
  localparam int unsigned DIV_DW     = 9;
  localparam int unsigned DIV_BITS   = 7;
  localparam int unsigned DIV_STAGES = DIV_NW / DIV_BITS;

  // Pipelined square root: input width, root width, remainder width
  localparam int unsigned SQ_IW     = 64;
  localparam int unsigned SQ_RW     = 32;
  localparam int unsigned SQ_REM_W  = 34;
  localparam int unsigned SQ_STEPS  = 2;
  localparam int unsigned SQ_STAGES = SQ_RW / SQ_STEPS;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // Reciprocals ceil(2^(30+l)/d) with 2^l >= d: exact floor division of 30-bit values
  localparam logic [63:0] SIN_M0 = ((64'd1 << 33) + 64'd5) / 64'd6;
  localparam logic [63:0] SIN_M1 = ((64'd1 << 35) + 64'd19) / 64'd20;
  localparam logic [63:0] SIN_M2 = ((64'd1 << 36) + 64'd41) / 64'd42;
  localparam logic [63:0] SIN_M3 = ((64'd1 << 37) + 64'd71) / 64'd72;
  localparam logic [63:0] COS_M0 = ((64'd1 << 34) + 64'd11) / 64'd12;
  localparam logic [63:0] COS_M1 = ((64'd1 << 35) + 64'd29) / 64'd30;
  localparam logic [63:0] COS_M2 = ((64'd1 << 36) + 64'd55) / 64'd56;
  localparam logic [63:0] COS_M3 = ((64'd1 << 37) + 64'd89) / 64'd90;

  localparam logic [30:0] SIN_RECIP [4] = '{SIN_M0[30:0], SIN_M1[30:0],
                                             SIN_M2[30:0], SIN_M3[30:0]};
  localparam logic [30:0] COS_RECIP [4] = '{COS_M0[30:0], COS_M1[30:0],
                                             COS_M2[30:0], COS_M3[30:0]};
  localparam int unsigned SIN_SHIFT [4] = '{33, 35, 36, 37};
  localparam int unsigned COS_SHIFT [4] = '{34, 35, 36, 37};

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic [STACK_W-1:0] ring_index;
    logic [RPT_W-1:0]   ring_point;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [63:0]        vertex_colour;
    logic [2:0]         index_count;
    logic [IDX_W-1:0]   tri_index_a;
    logic [IDX_W-1:0]   tri_index_b;
    logic [IDX_W-1:0]   tri_index_c;
    logic [IDX_W-1:0]   tri_index_d;
    logic [IDX_W-1:0]   tri_index_e;
    logic [IDX_W-1:0]   tri_index_f;
  } result_t;

endpackage

// File: hdl/usct_div.sv
`timescale 1ns / 1ps

module usct_div (
  input  logic                         clk_i,
  input  logic [usct_pkg::DIV_NW-1:0]  dividend_i,
  input  logic [usct_pkg::DIV_DW-1:0]  divisor_i,
  output logic [usct_pkg::DIV_NW-1:0]  quotient_o
);
  import usct_pkg::*;

  logic [DIV_DW-1:0] rem_q [DIV_STAGES];
  logic [DIV_DW-1:0] den_q [DIV_STAGES];
  logic [DIV_NW-1:0] num_q [DIV_STAGES];
  logic [DIV_NW-1:0] quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_DW-1:0] rem_in, rem_d, den_in;
    logic [DIV_NW-1:0] num_in, quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = divisor_i;
      assign num_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // restoring division, one quotient bit per step
    always_comb begin
      logic [DIV_DW:0] trial;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < DIV_BITS; j++) begin
        trial = {rem_d, num_in[DIV_NW-1-s*DIV_BITS-j]};
        if (trial >= {1'b0, den_in}) begin
          trial = trial - {1'b0, den_in};
          quo_d[DIV_NW-1-s*DIV_BITS-j] = 1'b1;
        end
        rem_d = trial[DIV_DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      den_q[s] <= den_in;
      num_q[s] <= num_in;
      quo_q[s] <= quo_d;
    end
  end

  assign quotient_o = quo_q[DIV_STAGES-1];

endmodule

// File: hdl/usct_sqrt.sv
`timescale 1ns / 1ps

module usct_sqrt (
  input  logic                       clk_i,
  input  logic [usct_pkg::SQ_IW-1:0] value_i,
  output logic [usct_pkg::SQ_RW-1:0] root_o
);
  import usct_pkg::*;

  logic [SQ_REM_W-1:0] rem_q  [SQ_STAGES];
  logic [SQ_RW-1:0]    root_q [SQ_STAGES];
  logic [SQ_IW-1:0]    val_q  [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_in, rem_d;
    logic [SQ_RW-1:0]    root_in, root_d;
    logic [SQ_IW-1:0]    val_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = value_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign val_in  = val_q[s-1];
    end

    // digit recurrence: bring down two bits, try root*4+1
    always_comb begin
      logic [SQ_REM_W+1:0] trial, cmp;
      rem_d  = rem_in;
      root_d = root_in;
      for (int j = 0; j < SQ_STEPS; j++) begin
        trial = {rem_d, val_in[SQ_IW-1-2*(s*SQ_STEPS+j) -: 2]};
        cmp   = (SQ_REM_W+2)'({root_d, 2'b01});
        if (trial >= cmp) begin
          trial  = trial - cmp;
          root_d = {root_d[SQ_RW-2:0], 1'b1};
        end else begin
          root_d = {root_d[SQ_RW-2:0], 1'b0};
        end
        rem_d = trial[SQ_REM_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
      val_q[s]  <= val_in;
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

// File: hdl/uv_sphere_cell_tessellator.sv
`timescale 1ns / 1ps

// Channel   Ports                              Transfer
// cell      start, busy, cell_i                start high and busy low at a clock edge
// result    done_o, result_o                   one cycle per item, marked by done_o
// config    cfg_we_i, cfg_idx_i, cfg_data_i    cfg_we_i high at a clock edge
//
// One cell enters per clock; busy stays low. Each result shows on done_o after the input
// register, the divider (6 stages), the ring-radius square root (16 stages) and the
// scale/offset stages around it. Results leave in order.
// Reset clears the valid bits and loads the register defaults; there is no
// clearing pass. The receiver cannot stall, so the pipeline always advances.
module uv_sphere_cell_tessellator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  usct_pkg::cell_t                   cell_i,
  output logic                              done_o,
  output usct_pkg::result_t                 result_o,
  input  logic                              cfg_we_i,
  input  logic [usct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [usct_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import usct_pkg::*;

  localparam int unsigned BK_DEPTH = 19;
  localparam int unsigned SC_DEPTH = 7;

  typedef struct packed {
    logic [31:0]           dy;
    logic [63:0]           colour;
    logic [2:0]            cnt;
    logic [5:0][IDX_W-1:0] idx;
  } bk_t;

  function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [29:0] b);
    logic [59:0] prod;
    prod = 60'(a) * 60'(b);
    return prod[59:30];
  endfunction

  function automatic logic [29:0] div_by_const(input logic [29:0] n, input logic [30:0] m,
                                               input int unsigned sh);
    logic [60:0] prod;
    prod = 61'(n) * 61'(m);
    return 30'(prod >> sh);
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {a[31], a} + {b[31], b};
    if (sum[32] != sum[31]) begin
      return sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return sum[31:0];
  endfunction

  // configuration registers
  logic [STACK_W-1:0] stack_count_q;
  logic [POINT_W-1:0] point_count_q;
  logic [30:0]        radius_q;
  logic [31:0]        center_x_q, center_y_q, center_z_q;
  logic [63:0]        base_colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_count_q <= STACK_W'(16);
      point_count_q <= POINT_W'(16);
      radius_q      <= 31'd65536;
      center_x_q    <= '0;
      center_y_q    <= '0;
      center_z_q    <= '0;
      base_colour_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STACK_COUNT:   stack_count_q <= cfg_data_i[STACK_W-1:0];
        CFG_POINT_COUNT:   point_count_q <= cfg_data_i[POINT_W-1:0];
        CFG_SPHERE_RADIUS: radius_q      <= cfg_data_i[30:0];
        CFG_CENTER_X:      center_x_q    <= cfg_data_i[31:0];
        CFG_CENTER_Y:      center_y_q    <= cfg_data_i[31:0];
        CFG_CENTER_Z:      center_z_q    <= cfg_data_i[31:0];
        CFG_BASE_COLOUR:   base_colour_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [STACK_W-1:0] s_clamp;
  logic [POINT_W-1:0] p_clamp, p_last;

  assign s_clamp = (stack_count_q < STACK_W'(MIN_STACKS)) ? STACK_W'(MIN_STACKS) :
                   (stack_count_q > STACK_W'(MAX_STACKS)) ? STACK_W'(MAX_STACKS) :
                   stack_count_q;
  assign p_clamp = (point_count_q < POINT_W'(MIN_POINTS)) ? POINT_W'(MIN_POINTS) :
                   (point_count_q > POINT_W'(MAX_POINTS)) ? POINT_W'(MAX_POINTS) :
                   point_count_q;
  assign p_last  = p_clamp - POINT_W'(1);

  assign busy = 1'b0;

  // input stage: saturate cell coordinates
  logic               in_vld_q;
  logic [STACK_W-1:0] in_k_q;
  logic [RPT_W-1:0]   in_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    in_k_q <= (cell_i.ring_index > s_clamp) ? s_clamp : cell_i.ring_index;
    in_p_q <= ({1'b0, cell_i.ring_point} >= p_clamp) ? p_last[RPT_W-1:0] : cell_i.ring_point;
  end

  // divider feed
  logic [STACK_W:0]   two_k, s_ext, num_ext;
  logic               in_neg;
  logic [37:0]        rnum;
  logic [POINT_W-1:0] p_inc;
  logic [DIV_NW-1:0]  dq, uq, iq;

  assign two_k   = {in_k_q, 1'b0};
  assign s_ext   = {1'b0, s_clamp};
  assign in_neg  = two_k < s_ext;
  assign num_ext = in_neg ? (s_ext - two_k) : (two_k - s_ext);
  assign rnum    = 38'(radius_q) * 38'(num_ext[STACK_W-1:0]);
  assign p_inc   = {1'b0, in_p_q} + POINT_W'(1);

  usct_div u_div_dy (
    .clk_i      (clk_i),
    .dividend_i (DIV_NW'(rnum)),
    .divisor_i  (DIV_DW'(s_clamp)),
    .quotient_o (dq)
  );

  usct_div u_div_phase (
    .clk_i      (clk_i),
    .dividend_i (DIV_NW'({p_inc, 32'b0})),
    .divisor_i  (DIV_DW'(p_clamp)),
    .quotient_o (uq)
  );

  usct_div u_div_tint (
    .clk_i      (clk_i),
    .dividend_i (DIV_NW'({in_k_q, 12'b0})),
    .divisor_i  (DIV_DW'(s_clamp)),
    .quotient_o (iq)
  );

  // side data alongside the dividers
  logic               fr_vld_q [DIV_STAGES];
  logic [STACK_W-1:0] fr_k_q   [DIV_STAGES];
  logic [RPT_W-1:0]   fr_p_q   [DIV_STAGES];
  logic               fr_neg_q [DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STAGES; i++) fr_vld_q[i] <= 1'b0;
    end else begin
      fr_vld_q[0] <= in_vld_q;
      for (int i = 1; i < DIV_STAGES; i++) fr_vld_q[i] <= fr_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    fr_k_q[0]   <= in_k_q;
    fr_p_q[0]   <= in_p_q;
    fr_neg_q[0] <= in_neg;
    for (int i = 1; i < DIV_STAGES; i++) begin
      fr_k_q[i]   <= fr_k_q[i-1];
      fr_p_q[i]   <= fr_p_q[i-1];
      fr_neg_q[i] <= fr_neg_q[i-1];
    end
  end

  // divider outputs: height, phase, tint, indices
  logic [30:0]        dmag;
  logic [31:0]        u;
  logic [12:0]        inc;
  logic [STACK_W-1:0] dk;
  logic [RPT_W-1:0]   dp;
  logic [2:0]         oct_d;
  logic [29:0]        x30;
  logic [61:0]        tprod;
  bk_t                bk_d;

  assign dmag  = dq[30:0];
  assign u     = uq[31:0];
  assign inc   = iq[12:0];
  assign dk    = fr_k_q[DIV_STAGES-1];
  assign dp    = fr_p_q[DIV_STAGES-1];
  assign oct_d = u[31:29];
  assign x30   = oct_d[0] ? ((30'd1 << 29) - {1'b0, u[28:0]}) : {1'b0, u[28:0]};
  assign tprod = 62'(x30) * 62'(PI_Q30);

  always_comb begin
    logic [IDX_W-1:0] lo, hi, pp, np;
    logic [16:0]      ch;
    bk_d.dy = fr_neg_q[DIV_STAGES-1] ? (32'd0 - {1'b0, dmag}) : {1'b0, dmag};
    for (int c = 0; c < 3; c++) begin
      ch = {1'b0, base_colour_q[16*c +: 16]} + 17'(inc);
      bk_d.colour[16*c +: 16] = ch[16] ? 16'hFFFF : ch[15:0];
    end
    bk_d.colour[63:48] = base_colour_q[63:48];
    lo = IDX_W'(dk) * IDX_W'(p_clamp);
    hi = lo + IDX_W'(p_clamp);
    pp = IDX_W'(dp);
    np = ({1'b0, dp} == p_last) ? '0 : pp + IDX_W'(1);
    bk_d.idx = '0;
    bk_d.cnt = 3'd0;
    if (dk < s_clamp) begin
      if (dk == '0) begin
        bk_d.idx[0] = lo + pp;
        bk_d.idx[1] = hi + pp;
        bk_d.idx[2] = hi + np;
        bk_d.cnt    = 3'd3;
      end else if (dk == s_clamp - STACK_W'(1)) begin
        bk_d.idx[0] = lo + pp;
        bk_d.idx[1] = hi;
        bk_d.idx[2] = lo + np;
        bk_d.cnt    = 3'd3;
      end else begin
        bk_d.idx[0] = lo + pp;
        bk_d.idx[1] = hi + pp;
        bk_d.idx[2] = lo + np;
        bk_d.idx[3] = lo + np;
        bk_d.idx[4] = hi + pp;
        bk_d.idx[5] = hi + np;
        bk_d.cnt    = 3'd6;
      end
    end
  end

  logic bk_vld_q [BK_DEPTH];
  bk_t  bk_q     [BK_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BK_DEPTH; i++) bk_vld_q[i] <= 1'b0;
    end else begin
      bk_vld_q[0] <= fr_vld_q[DIV_STAGES-1];
      for (int i = 1; i < BK_DEPTH; i++) bk_vld_q[i] <= bk_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    bk_q[0] <= bk_d;
    for (int i = 1; i < BK_DEPTH; i++) bk_q[i] <= bk_q[i-1];
  end

  // ring radius: r^2 - dy^2 into the square root
  logic [61:0] rr_q, dd_q, diff_q;
  logic [31:0] root;

  always_ff @(posedge clk_i) begin
    rr_q   <= 62'(radius_q) * 62'(radius_q);
    dd_q   <= 62'(dmag) * 62'(dmag);
    diff_q <= rr_q - dd_q;
  end

  usct_sqrt u_sqrt (
    .clk_i   (clk_i),
    .value_i (SQ_IW'(diff_q)),
    .root_o  (root)
  );

  // sine and cosine: Taylor series, one multiply per stage
  logic [29:0] t1_q;
  logic [2:0]  oct_q    [11];
  logic [29:0] t2_q     [8];
  logic [29:0] sin_t_q  [4];
  logic [29:0] sin_p_q  [4];
  logic [31:0] sin_ps_q [4];
  logic [31:0] sin_s_q  [5];
  logic [29:0] cos_t_q  [4];
  logic [29:0] cos_p_q  [4];
  logic [31:0] cos_ps_q [4];
  logic [31:0] cos_s_q  [5];
  logic [31:0] sin_dly_q;
  logic [29:0] sin_term [4];
  logic [29:0] cos_term [4];

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      sin_term[n] = div_by_const(sin_p_q[n], SIN_RECIP[n], SIN_SHIFT[n]);
      cos_term[n] = div_by_const(cos_p_q[n], COS_RECIP[n], COS_SHIFT[n]);
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q     <= tprod[60:31];
    oct_q[0] <= oct_d;
    for (int i = 1; i < 11; i++) oct_q[i] <= oct_q[i-1];
    t2_q[0]  <= mul_q30(t1_q, t1_q);
    for (int i = 1; i < 8; i++) t2_q[i] <= t2_q[i-1];

    sin_t_q[0] <= t1_q;
    sin_s_q[0] <= {2'b0, t1_q};
    cos_t_q[0] <= {1'b0, t2_q[0][29:1]};
    cos_s_q[0] <= Q30_ONE - {3'b0, t2_q[0][29:1]};

    for (int n = 0; n < 4; n++) begin
      sin_p_q[n]  <= mul_q30(sin_t_q[n], t2_q[2*n]);
      sin_ps_q[n] <= sin_s_q[n];
      cos_p_q[n]  <= mul_q30(cos_t_q[n], t2_q[2*n+1]);
      cos_ps_q[n] <= cos_s_q[n];
      // alternate signs: sine subtracts first, cosine adds first
      sin_s_q[n+1] <= (n % 2 == 0) ? (sin_ps_q[n] - {2'b0, sin_term[n]})
                                   : (sin_ps_q[n] + {2'b0, sin_term[n]});
      cos_s_q[n+1] <= (n % 2 == 0) ? (cos_ps_q[n] + {2'b0, cos_term[n]})
                                   : (cos_ps_q[n] - {2'b0, cos_term[n]});
      if (n < 3) begin
        sin_t_q[n+1] <= sin_term[n];
        cos_t_q[n+1] <= cos_term[n];
      end
    end
    sin_dly_q <= sin_s_q[4];
  end

  // fold octant back to the full circle
  logic [31:0] s_fold, sv_d, cv_d;
  logic [3:0]  oct_inc;
  logic [1:0]  quad;
  logic [2:0]  oct_f;

  assign oct_f   = oct_q[10];
  assign s_fold  = oct_f[0] ? (32'd0 - sin_dly_q) : sin_dly_q;
  assign oct_inc = {1'b0, oct_f} + 4'd1;
  assign quad    = oct_f[0] ? oct_inc[2:1] : oct_f[2:1];

  always_comb begin
    case (quad)
      QUAD_0: begin
        sv_d = s_fold;
        cv_d = cos_s_q[4];
      end
      QUAD_1: begin
        sv_d = cos_s_q[4];
        cv_d = 32'd0 - s_fold;
      end
      QUAD_2: begin
        sv_d = 32'd0 - s_fold;
        cv_d = 32'd0 - cos_s_q[4];
      end
      default: begin
        sv_d = 32'd0 - cos_s_q[4];
        cv_d = s_fold;
      end
    endcase
  end

  logic [31:0] sv_q [SC_DEPTH];
  logic [31:0] cv_q [SC_DEPTH];

  always_ff @(posedge clk_i) begin
    sv_q[0] <= sv_d;
    cv_q[0] <= cv_d;
    for (int i = 1; i < SC_DEPTH; i++) begin
      sv_q[i] <= sv_q[i-1];
      cv_q[i] <= cv_q[i-1];
    end
  end

  // scale by ring radius, truncate toward zero
  logic [30:0] smag, cmag;
  logic [61:0] xprod, zprod;
  logic [31:0] px_q, pz_q;

  assign smag  = sv_q[SC_DEPTH-1][31] ? 31'(32'd0 - sv_q[SC_DEPTH-1]) : sv_q[SC_DEPTH-1][30:0];
  assign cmag  = cv_q[SC_DEPTH-1][31] ? 31'(32'd0 - cv_q[SC_DEPTH-1]) : cv_q[SC_DEPTH-1][30:0];
  assign xprod = 62'(root[30:0]) * 62'(smag);
  assign zprod = 62'(root[30:0]) * 62'(cmag);

  always_ff @(posedge clk_i) begin
    px_q <= sv_q[SC_DEPTH-1][31] ? (32'd0 - {1'b0, xprod[60:30]}) : {1'b0, xprod[60:30]};
    pz_q <= cv_q[SC_DEPTH-1][31] ? (32'd0 - {1'b0, zprod[60:30]}) : {1'b0, zprod[60:30]};
  end

  // output register
  result_t res_q;
  logic    done_q;
  bk_t     bk_l;

  assign bk_l = bk_q[BK_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= bk_vld_q[BK_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.vertex_x      <= sat_add(center_x_q, px_q);
    res_q.vertex_y      <= sat_add(center_y_q, bk_l.dy);
    res_q.vertex_z      <= sat_add(center_z_q, pz_q);
    res_q.vertex_colour <= bk_l.colour;
    res_q.index_count   <= bk_l.cnt;
    res_q.tri_index_a   <= bk_l.idx[0];
    res_q.tri_index_b   <= bk_l.idx[1];
    res_q.tri_index_c   <= bk_l.idx[2];
    res_q.tri_index_d   <= bk_l.idx[3];
    res_q.tri_index_e   <= bk_l.idx[4];
    res_q.tri_index_f   <= bk_l.idx[5];
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import usct_pkg::*;

  localparam int unsigned LATENCY   = 26;
  localparam int unsigned MAX_CYCLE = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cell_t cell_i = '0;
  logic done_o;
  result_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_STACK_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  uv_sphere_cell_tessellator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cell_i(cell_i),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the registers
  logic [6:0]  m_stacks;
  logic [8:0]  m_points;
  logic [30:0] m_radius;
  logic signed [31:0] m_cx, m_cy, m_cz;
  logic [63:0] m_colour;

  result_t vertex_queue[$];
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_sent = 0;
  int unsigned cycle = 0;
  int unsigned send_idle_pct = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle);
    n_errors++;
  endtask

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bits, rem;
    res = 0; bits = 64'd1 << 62; rem = v;
    while (bits > rem) bits >>= 2;
    while (bits != 0) begin
      if (rem >= res + bits) begin
        rem -= res + bits; res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  task automatic octant_trig(input longint unsigned t, output longint s,
                             output longint c);
    longint unsigned t2, term;
    longint sum;
    t2 = (t * t) >> 30;
    term = t; sum = t;
    for (int n = 1; n <= 4; n++) begin
      term = ((term * t2) >> 30) / ((2 * n) * (2 * n + 1));
      sum += (n & 1) ? -longint'(term) : longint'(term);
    end
    s = sum;
    term = 64'd1 << 30; sum = 64'd1 << 30;
    for (int n = 1; n <= 5; n++) begin
      term = ((term * t2) >> 30) / ((2 * n - 1) * (2 * n));
      sum += (n & 1) ? -longint'(term) : longint'(term);
    end
    c = sum;
  endtask

  task automatic turn_trig(input longint unsigned u, output longint sv,
                           output longint cv);
    longint unsigned oct, f, x, q;
    longint s, c;
    oct = (u >> 29) & 7; f = u & ((64'd1 << 29) - 1);
    x = oct[0] ? ((64'd1 << 29) - f) : f;
    q = oct[0] ? (((oct + 1) >> 1) & 3) : (oct >> 1);
    octant_trig((x * 64'(PI_Q30)) >> 31, s, c);
    if (oct[0]) s = -s;
    case (q)
      0: begin sv = s;  cv = c;  end
      1: begin sv = c;  cv = -s; end
      2: begin sv = -s; cv = -c; end
      default: begin sv = -c; cv = s; end
    endcase
  endtask

  function automatic longint scale_ring(input longint unsigned r, input longint v);
    longint unsigned mag;
    longint p;
    mag = (v < 0) ? longint'(-v) : v;
    p = longint'((r * mag) >> 30);
    return (v < 0) ? -p : p;
  endfunction

  function automatic logic [31:0] clamp_coord(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic predict_cell(input cell_t c, output result_t res);
    longint unsigned s, p, r, k, pt, num, dmag, rr, u, inc, np, lo, hi, ch;
    longint dy, sv, cv;
    s = 64'(m_stacks); p = 64'(m_points); r = 64'(m_radius);
    k = 64'(c.ring_index); pt = 64'(c.ring_point);
    if (s < MIN_STACKS) s = MIN_STACKS;
    if (s > MAX_STACKS) s = MAX_STACKS;
    if (p < MIN_POINTS) p = MIN_POINTS;
    if (p > MAX_POINTS) p = MAX_POINTS;
    if (k > s) k = s;
    if (pt >= p) pt = p - 1;
    num = (2 * k >= s) ? (2 * k - s) : (s - 2 * k);
    dmag = (r * num) / s;
    dy = (2 * k < s) ? -longint'(dmag) : longint'(dmag);
    rr = root_floor(r * r - dmag * dmag);
    u = (((pt + 1) << 32) / p) & 64'hffff_ffff;
    turn_trig(u, sv, cv);
    res = '0;
    res.vertex_x = clamp_coord(longint'(m_cx) + scale_ring(rr, sv));
    res.vertex_y = clamp_coord(longint'(m_cy) + dy);
    res.vertex_z = clamp_coord(longint'(m_cz) + scale_ring(rr, cv));
    inc = (k * 4096) / s;
    for (int i = 0; i < 3; i++) begin
      ch = 64'(m_colour[16*i +: 16]) + inc;
      res.vertex_colour[16*i +: 16] = (ch > 64'hffff) ? 16'hffff : ch[15:0];
    end
    res.vertex_colour[63:48] = m_colour[63:48];
    np = (pt == p - 1) ? 0 : pt + 1;
    lo = k * p; hi = (k + 1) * p;
    if (k < s) begin
      if (k == 0) begin
        res.tri_index_a = IDX_W'(lo + pt); res.tri_index_b = IDX_W'(hi + pt);
        res.tri_index_c = IDX_W'(hi + np); res.index_count = 3'd3;
      end else if (k == s - 1) begin
        res.tri_index_a = IDX_W'(lo + pt); res.tri_index_b = IDX_W'(hi);
        res.tri_index_c = IDX_W'(lo + np); res.index_count = 3'd3;
      end else begin
        res.tri_index_a = IDX_W'(lo + pt); res.tri_index_b = IDX_W'(hi + pt);
        res.tri_index_c = IDX_W'(lo + np); res.tri_index_d = IDX_W'(lo + np);
        res.tri_index_e = IDX_W'(hi + pt); res.tri_index_f = IDX_W'(hi + np);
        res.index_count = 3'd6;
      end
    end
  endtask

  // checker: compare each strobed vertex with the oldest prediction
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni && done_o) begin
      if (vertex_queue.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd0);
      end else begin
        result_t w;
        w = vertex_queue.pop_front();
        n_checked++;
        if (result_o.vertex_x !== w.vertex_x)
          report_mismatch("vertex_x", 64'(result_o.vertex_x), 64'(w.vertex_x));
        if (result_o.vertex_y !== w.vertex_y)
          report_mismatch("vertex_y", 64'(result_o.vertex_y), 64'(w.vertex_y));
        if (result_o.vertex_z !== w.vertex_z)
          report_mismatch("vertex_z", 64'(result_o.vertex_z), 64'(w.vertex_z));
        if (result_o.vertex_colour !== w.vertex_colour)
          report_mismatch("vertex_colour", result_o.vertex_colour, w.vertex_colour);
        if (result_o.index_count !== w.index_count)
          report_mismatch("index_count", 64'(result_o.index_count), 64'(w.index_count));
        if (result_o.tri_index_a !== w.tri_index_a)
          report_mismatch("tri_index_a", 64'(result_o.tri_index_a), 64'(w.tri_index_a));
        if (result_o.tri_index_b !== w.tri_index_b)
          report_mismatch("tri_index_b", 64'(result_o.tri_index_b), 64'(w.tri_index_b));
        if (result_o.tri_index_c !== w.tri_index_c)
          report_mismatch("tri_index_c", 64'(result_o.tri_index_c), 64'(w.tri_index_c));
        if (result_o.tri_index_d !== w.tri_index_d)
          report_mismatch("tri_index_d", 64'(result_o.tri_index_d), 64'(w.tri_index_d));
        if (result_o.tri_index_e !== w.tri_index_e)
          report_mismatch("tri_index_e", 64'(result_o.tri_index_e), 64'(w.tri_index_e));
        if (result_o.tri_index_f !== w.tri_index_f)
          report_mismatch("tri_index_f", 64'(result_o.tri_index_f), 64'(w.tri_index_f));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle >= MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    case (idx)
      CFG_STACK_COUNT:   m_stacks = val[6:0];
      CFG_POINT_COUNT:   m_points = val[8:0];
      CFG_SPHERE_RADIUS: m_radius = val[30:0];
      CFG_CENTER_X:      m_cx = val[31:0];
      CFG_CENTER_Y:      m_cy = val[31:0];
      CFG_CENTER_Z:      m_cz = val[31:0];
      CFG_BASE_COLOUR:   m_colour = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one item at the current edge, with random gaps before it; returns at the
  // accepting edge with start still high, so the next item can follow straight away
  task automatic send_cell(input cell_t c);
    result_t w;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    start <= 1'b1; cell_i <= c;
    do @(posedge clk_i); while (busy);
    predict_cell(c, w);
    vertex_queue.push_back(w);
    n_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic random_cfg(input int mode);
    logic [63:0] v;
    write_reg(CFG_STACK_COUNT, (mode == 0) ? 64'd2 : (mode == 1) ? 64'd64 :
              64'($urandom_range(127)));
    write_reg(CFG_POINT_COUNT, (mode == 0) ? 64'd3 : (mode == 1) ? 64'd256 :
              64'($urandom_range(511)));
    v = (mode == 1) ? 64'h7fff_ffff : ($urandom_range(3) == 0) ? 64'($urandom) :
        64'($urandom_range(32'h0080_0000));
    write_reg(CFG_SPHERE_RADIUS, v);
    write_reg(CFG_CENTER_X, (mode == 1) ? 64'h7fff_ffff : 64'($urandom));
    write_reg(CFG_CENTER_Y, (mode == 1) ? 64'h8000_0000 : 64'($urandom));
    write_reg(CFG_CENTER_Z, ($urandom_range(1)) ? 64'($urandom_range(4096)) :
              64'($urandom));
    write_reg(CFG_BASE_COLOUR, (mode == 1) ? 64'hffff_ffff_ffff_ffff :
              {32'($urandom), 32'($urandom)});
  endtask

  typedef struct {
    logic [6:0] k;
    logic [7:0] p;
    bit         known;
    logic [2:0] cnt;
    logic [14:0] ia;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{7'd0,   8'd0,   1'b1, 3'd3, 15'd0},
    '{7'd16,  8'd0,   1'b1, 3'd0, 15'd0},
    '{7'd15,  8'd15,  1'b1, 3'd3, 15'd255},
    '{7'd1,   8'd3,   1'b1, 3'd6, 15'd19},
    '{7'd127, 8'd255, 1'b1, 3'd0, 15'd0},
    '{7'd8,   8'd7,   1'b0, 3'd0, 15'd0},
    '{7'd0,   8'd15,  1'b0, 3'd0, 15'd0},
    '{7'd15,  8'd0,   1'b0, 3'd0, 15'd0},
    '{7'd4,   8'd200, 1'b0, 3'd0, 15'd0},
    '{7'd12,  8'd9,   1'b0, 3'd0, 15'd0},
    '{7'd85,  8'd170, 1'b0, 3'd0, 15'd0},
    '{7'd42,  8'd85,  1'b0, 3'd0, 15'd0}
  };

  initial begin
    cell_t c;
    int unsigned phase_len;
    m_stacks = 16; m_points = 16; m_radius = 31'd65536;
    m_cx = 0; m_cy = 0; m_cz = 0; m_colour = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset defaults; typed-in fields checked on top of the predictor
    foreach (directed_rows[i]) begin
      result_t w;
      c.ring_index = directed_rows[i].k; c.ring_point = directed_rows[i].p;
      send_cell(c);
      if (directed_rows[i].known) begin
        w = vertex_queue[$];
        if (w.index_count !== directed_rows[i].cnt)
          report_mismatch("table index_count", 64'(w.index_count),
                          64'(directed_rows[i].cnt));
        if (w.tri_index_a !== directed_rows[i].ia)
          report_mismatch("table tri_index_a", 64'(w.tri_index_a),
                          64'(directed_rows[i].ia));
      end
    end
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      random_cfg(phase < 2 ? phase : 2);
      send_idle_pct = (phase < 4) ? 32 : (phase < 8) ? 87 : 0;
      phase_len = 100;
      for (int n = 0; n < phase_len; n++) begin
        if ($urandom_range(9) == 0) begin
          c.ring_index = 7'($urandom); c.ring_point = 8'($urandom);
        end else begin
          c.ring_index = 7'($urandom_range((m_stacks > 64) ? 64 : m_stacks));
          c.ring_point = 8'($urandom_range((m_points > 256) ? 255 :
                         (m_points == 0) ? 0 : m_points - 1));
        end
        send_cell(c);
        if (n == 50 && phase == 9) begin
          // hold off until the pipeline is empty
          start <= 1'b0;
          while (vertex_queue.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("covered %0d cells, %0d results checked over 13 register settings",
             n_sent, n_checked);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/usct_pkg.sv
hdl/usct_div.sv
hdl/usct_sqrt.sv
hdl/uv_sphere_cell_tessellator.sv
dv/tb_top.sv
